/* src/hrsp_pkg.sv */
package hrsp_pkg;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_REQ  = 2'd0,
        PH_HDR  = 2'd1,
        PH_BODY = 2'd2,
        PH_ERR  = 2'd3
    } t_phase;

    // Field kind carried by each result beat.
    typedef enum logic [2:0] {
        FK_NONE    = 3'd0,
        FK_METHOD  = 3'd1,
        FK_PATH    = 3'd2,
        FK_VERSION = 3'd3,
        FK_NAME    = 3'd4,
        FK_VALUE   = 3'd5,
        FK_BODY    = 3'd6
    } t_kind;

    // Position within a header line.
    typedef enum logic [1:0] {
        HP_EMPTY = 2'd0,
        HP_NAME  = 2'd1,
        HP_SKIP  = 2'd2,
        HP_VALUE = 2'd3
    } t_hpart;

    // Content length number scanner.
    typedef enum logic [2:0] {
        NS_SKIP   = 3'd0,
        NS_PLUS   = 3'd1,
        NS_MINUS  = 3'd2,
        NS_DIGITS = 3'd3,
        NS_NEG    = 3'd4,
        NS_STOP   = 3'd5,
        NS_OVF    = 3'd6,
        NS_BAD    = 3'd7
    } t_nstage;

    // Operation on the length accumulator.
    typedef enum logic [1:0] {
        AO_NONE  = 2'd0,
        AO_CLEAR = 2'd1,
        AO_LOAD  = 2'd2,
        AO_MAC   = 2'd3
    } t_accop;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_QM    = 8'h3F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [3:0] NAME_LEN   = 4'd14;
    localparam logic [3:0] MATCH_FAIL = 4'd15;
    localparam int unsigned BLEN_W    = 24;

    // One result beat without the per-item status bits.
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        t_kind      kind;
        logic       fend;
        logic       drop;
        logic       done;
    } t_res;

    // Parser state apart from the length counters.
    typedef struct packed {
        t_phase     phase;
        logic [1:0] tok_idx;
        logic       in_tok;
        logic       query;
        logic [1:0] pct;
        logic [7:0] held;
        logic       cr_pend;
        t_hpart     hdr_part;
        logic [3:0] pend_sp;
        logic [3:0] match;
        t_nstage    num_stage;
        logic       len_seen;
    } t_pstate;

    // Effect of one line byte.
    typedef struct packed {
        t_pstate      s;
        logic [1:0]   n;
        t_res [1:0]   r;
        logic [3:0]   spaces;
        t_accop       op;
    } t_line;

    // All beats caused by one input item: held spaces first, then the slots.
    typedef struct packed {
        logic [3:0]        spaces;
        logic [1:0]        nslots;
        t_res [2:0]        slot;
        logic              perr;
        logic [BLEN_W-1:0] blen;
    } t_bundle;

    function automatic t_res mk_res(input logic [7:0] data, input logic valid,
                                    input t_kind kind, input logic fend,
                                    input logic drop, input logic done);
        t_res r;
        r.data  = data;
        r.valid = valid;
        r.kind  = kind;
        r.fend  = fend;
        r.drop  = drop;
        r.done  = done;
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
    endfunction

    // Hex digit value; bit 4 set when the character is a digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if ((c >= CH_0) && (c <= CH_9)) begin
            v = {1'b1, c[3:0]};
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            v = {1'b1, c[3:0] + 4'd9};
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    // Decode a percent escape the way a base 16 conversion reads two characters.
    function automatic logic [7:0] hex_pair(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] ha;
        logic [4:0] hb;
        logic [7:0] v;
        ha = hex_val(a);
        hb = hex_val(b);
        v  = 8'd0;
        if (ha[4]) begin
            v = hb[4] ? {ha[3:0], hb[3:0]} : {4'd0, ha[3:0]};
        end else if ((a == CH_PLUS) || (a == CH_MINUS)) begin
            v = hb[4] ? {4'd0, hb[3:0]} : 8'd0;
            if (a == CH_MINUS) begin
                v = 8'd0 - v;
            end
        end
        return v;
    endfunction

    // Lower-case spelling of the content length header name.
    function automatic logic [7:0] name_char(input logic [3:0] i);
        logic [7:0] ch;
        unique case (i)
            4'd0:    ch = 8'h63;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h6C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* src/hrsp_if.sv */
interface hrsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       restart;

    modport source (output valid, output in_byte, output restart, input ready);
    modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

interface hrsp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic [2:0]  field_kind;
    logic        field_end;
    logic        drop_line;
    logic        request_done;
    logic        parse_error;
    logic [23:0] body_length;
    logic        last;

    modport source (output valid, output out_byte, output out_valid, output field_kind,
                    output field_end, output drop_line, output request_done,
                    output parse_error, output body_length, output last, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input field_kind,
                    input field_end, input drop_line, input request_done,
                    input parse_error, input body_length, input last, output ready);
endinterface

/* src/hrsp_step.sv */
module hrsp_step
    import hrsp_pkg::*;
#(
    parameter int LENGTH_BITS = 24,
    parameter int SPACE_HOLD  = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic                i_restart,
    input  logic                i_cfg_we,
    input  logic [BLEN_W-1:0]   i_cfg_data,
    output t_bundle             o_bundle
);

    localparam int HOLD = (SPACE_HOLD > 8) ? 8 : ((SPACE_HOLD < 1) ? 1 : SPACE_HOLD);
    localparam int CW   = (LENGTH_BITS > BLEN_W) ? LENGTH_BITS : BLEN_W;

    t_pstate                r_state, n_state;
    logic [LENGTH_BITS-1:0] r_acc, n_acc;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [BLEN_W-1:0]      r_max;

    logic [LENGTH_BITS+3:0] prod;
    logic                   ovf;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [LENGTH_BITS+BLEN_W-1:0] acc_ext;
    t_pstate                s_base;
    t_line                  l1, l2, le;
    logic [7:0]             first_c;

    // Close the current request line token.
    function automatic t_line end_token(input t_pstate si);
        t_line   l;
        t_pstate s;
        l = '0;
        s = si;
        if ((s.tok_idx == 2'd1) && (s.pct == 2'd2)) begin
            if (s.held == CH_PLUS) begin
                l.r[l.n[0]] = mk_res(CH_SP, 1'b1, FK_PATH, 1'b0, 1'b0, 1'b0);
                l.n = l.n + 2'd1;
            end else if (s.held != CH_PCT) begin
                l.r[l.n[0]] = mk_res(s.held, 1'b1, FK_PATH, 1'b0, 1'b0, 1'b0);
                l.n = l.n + 2'd1;
            end
        end
        if (s.tok_idx != 2'd3) begin
            l.r[l.n[0]] = mk_res(8'd0, 1'b0, t_kind'({1'b0, s.tok_idx} + 3'd1),
                                 1'b1, 1'b0, 1'b0);
            l.n = l.n + 2'd1;
            s.tok_idx = s.tok_idx + 2'd1;
        end
        s.in_tok = 1'b0;
        s.query  = 1'b0;
        s.pct    = 2'd0;
        l.s      = s;
        return l;
    endfunction

    // One byte of a request line or header line.
    function automatic t_line line_byte(input t_pstate si, input logic [7:0] c,
                                        input logic ovf_in);
        t_line      l;
        t_pstate    s;
        logic [7:0] lc;
        logic       dig;
        l   = '0;
        s   = si;
        dig = (c >= CH_0) && (c <= CH_9);
        lc  = to_lower(c);
        if (s.phase == PH_REQ) begin
            if (is_ws(c)) begin
                if (s.in_tok) begin
                    l = end_token(s);
                    s = l.s;
                end
            end else begin
                s.in_tok = 1'b1;
                if (s.tok_idx == 2'd1) begin
                    if (!s.query) begin
                        if (c == CH_QM) begin
                            if (s.pct == 2'd2) begin
                                if (s.held == CH_PLUS) begin
                                    l.r[l.n[0]] = mk_res(CH_SP, 1'b1, FK_PATH, 1'b0, 1'b0, 1'b0);
                                    l.n = l.n + 2'd1;
                                end else if (s.held != CH_PCT) begin
                                    l.r[l.n[0]] = mk_res(s.held, 1'b1, FK_PATH, 1'b0, 1'b0, 1'b0);
                                    l.n = l.n + 2'd1;
                                end
                            end
                            s.pct   = 2'd0;
                            s.query = 1'b1;
                        end else if (s.pct == 2'd1) begin
                            s.held = c;
                            s.pct  = 2'd2;
                        end else if (s.pct == 2'd2) begin
                            l.r[l.n[0]] = mk_res(hex_pair(s.held, c), 1'b1, FK_PATH,
                                                 1'b0, 1'b0, 1'b0);
                            l.n   = l.n + 2'd1;
                            s.pct = 2'd0;
                        end else if (c == CH_PCT) begin
                            s.pct = 2'd1;
                        end else if (c == CH_PLUS) begin
                            l.r[l.n[0]] = mk_res(CH_SP, 1'b1, FK_PATH, 1'b0, 1'b0, 1'b0);
                            l.n = l.n + 2'd1;
                        end else begin
                            l.r[l.n[0]] = mk_res(c, 1'b1, FK_PATH, 1'b0, 1'b0, 1'b0);
                            l.n = l.n + 2'd1;
                        end
                    end
                end else if (s.tok_idx != 2'd3) begin
                    l.r[l.n[0]] = mk_res(c, 1'b1, t_kind'({1'b0, s.tok_idx} + 3'd1),
                                         1'b0, 1'b0, 1'b0);
                    l.n = l.n + 2'd1;
                end
            end
        end else if ((s.hdr_part == HP_SKIP) || (s.hdr_part == HP_VALUE)) begin
            // Header value: leading blanks dropped, content length scanned.
            if (!((s.hdr_part == HP_SKIP) && ((c == CH_SP) || (c == CH_TAB)))) begin
                s.hdr_part  = HP_VALUE;
                l.r[l.n[0]] = mk_res(c, 1'b1, FK_VALUE, 1'b0, 1'b0, 1'b0);
                l.n = l.n + 2'd1;
                if (s.match == NAME_LEN) begin
                    unique case (s.num_stage)
                        NS_SKIP: begin
                            if (!is_ws(c)) begin
                                if (c == CH_PLUS) begin
                                    s.num_stage = NS_PLUS;
                                end else if (c == CH_MINUS) begin
                                    s.num_stage = NS_MINUS;
                                end else if (dig) begin
                                    l.op        = AO_LOAD;
                                    s.num_stage = NS_DIGITS;
                                end else begin
                                    s.num_stage = NS_BAD;
                                end
                            end
                        end
                        NS_PLUS: begin
                            if (dig) begin
                                l.op        = AO_LOAD;
                                s.num_stage = NS_DIGITS;
                            end else begin
                                s.num_stage = NS_BAD;
                            end
                        end
                        NS_MINUS: begin
                            s.num_stage = dig ? NS_NEG : NS_BAD;
                        end
                        NS_DIGITS: begin
                            if (!dig) begin
                                s.num_stage = NS_STOP;
                            end else if (ovf_in) begin
                                s.num_stage = NS_OVF;
                            end else begin
                                l.op = AO_MAC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end else begin
            // Header name: lower-cased, trailing spaces held back.
            s.hdr_part = HP_NAME;
            if (c == CH_COLON) begin
                s.pend_sp   = 4'd0;
                l.r[l.n[0]] = mk_res(8'd0, 1'b0, FK_NAME, 1'b1, 1'b0, 1'b0);
                l.n = l.n + 2'd1;
                s.hdr_part  = HP_SKIP;
                if (s.match == NAME_LEN) begin
                    s.len_seen  = 1'b1;
                    l.op        = AO_CLEAR;
                    s.num_stage = NS_SKIP;
                end
            end else if (c == CH_SP) begin
                if (s.pend_sp < 4'(HOLD)) begin
                    s.pend_sp = s.pend_sp + 4'd1;
                end else begin
                    l.r[l.n[0]] = mk_res(CH_SP, 1'b1, FK_NAME, 1'b0, 1'b0, 1'b0);
                    l.n = l.n + 2'd1;
                end
            end else begin
                if (s.pend_sp != 4'd0) begin
                    l.spaces  = s.pend_sp;
                    s.pend_sp = 4'd0;
                    s.match   = MATCH_FAIL;
                end
                if ((s.match < NAME_LEN) && (lc == name_char(s.match))) begin
                    s.match = s.match + 4'd1;
                end else begin
                    s.match = MATCH_FAIL;
                end
                l.r[l.n[0]] = mk_res(lc, 1'b1, FK_NAME, 1'b0, 1'b0, 1'b0);
                l.n = l.n + 2'd1;
            end
        end
        l.s = s;
        return l;
    endfunction

    // Accumulator times ten plus the digit, with its overflow.
    assign prod    = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + (LENGTH_BITS+4)'(i_byte[3:0]);
    assign ovf     = (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0);
    assign rem_dec = r_rem - LENGTH_BITS'(1);
    assign acc_ext = {{BLEN_W{1'b0}}, r_acc};

    // Line byte units: a held CR goes through first, then the new byte.
    always_comb begin
        s_base         = r_state;
        s_base.cr_pend = 1'b0;
    end
    assign first_c = r_state.cr_pend ? CH_CR : i_byte;
    assign l1      = line_byte(s_base, first_c, ovf);
    assign l2      = line_byte(l1.s, i_byte, ovf);
    assign le      = end_token(s_base);

    // Next state and the result bundle of the item.
    always_comb begin
        t_line      sel_a;
        t_line      sel_b;
        logic       use_a;
        logic       use_b;
        logic [2:0] cnt;
        t_accop     op;
        n_state  = r_state;
        n_acc    = r_acc;
        n_rem    = r_rem;
        o_bundle = '0;
        sel_a    = l1;
        sel_b    = l2;
        use_a    = 1'b0;
        use_b    = 1'b0;
        cnt      = 3'd0;
        op       = AO_NONE;
        if (i_restart) begin
            n_state = '0;
            n_acc   = '0;
            n_rem   = '0;
        end else if (r_state.phase == PH_ERR) begin
            n_state = r_state;
        end else if (r_state.phase == PH_BODY) begin
            n_rem = rem_dec;
            if (rem_dec == '0) begin
                o_bundle.slot[0] = mk_res(i_byte, 1'b1, FK_BODY, 1'b1, 1'b0, 1'b1);
                o_bundle.blen    = acc_ext[BLEN_W-1:0];
                cnt     = 3'd1;
                n_state = '0;
                n_acc   = '0;
                n_rem   = '0;
            end else begin
                o_bundle.slot[0] = mk_res(i_byte, 1'b1, FK_BODY, 1'b0, 1'b0, 1'b0);
                cnt = 3'd1;
            end
        end else if (r_state.cr_pend && (i_byte == CH_LF)) begin
            n_state = s_base;
            if (r_state.phase == PH_REQ) begin
                if (r_state.in_tok) begin
                    sel_a   = le;
                    use_a   = 1'b1;
                    n_state = le.s;
                end
                if (n_state.tok_idx != 2'd3) begin
                    n_state.phase = PH_ERR;
                end else begin
                    n_state.phase    = PH_HDR;
                    n_state.tok_idx  = 2'd0;
                    n_state.in_tok   = 1'b0;
                    n_state.query    = 1'b0;
                    n_state.pct      = 2'd0;
                    n_state.hdr_part = HP_EMPTY;
                    n_state.pend_sp  = 4'd0;
                    n_state.match    = 4'd0;
                end
            end else if (r_state.hdr_part == HP_EMPTY) begin
                // Blank line: end of the headers.
                if (r_state.len_seen && ((r_state.num_stage == NS_DIGITS) ||
                    (r_state.num_stage == NS_STOP)) && (r_acc != '0)) begin
                    if (CW'(r_acc) > CW'(r_max)) begin
                        n_state.phase = PH_ERR;
                    end else begin
                        n_state.phase = PH_BODY;
                        n_rem         = r_acc;
                    end
                end else if (r_state.len_seen && (r_state.num_stage == NS_OVF)) begin
                    n_state.phase = PH_ERR;
                end else begin
                    o_bundle.slot[0] = mk_res(8'd0, 1'b0, FK_NONE, 1'b0, 1'b0, 1'b1);
                    cnt     = 3'd1;
                    n_state = '0;
                    n_acc   = '0;
                    n_rem   = '0;
                end
            end else begin
                if (r_state.hdr_part == HP_NAME) begin
                    o_bundle.slot[0] = mk_res(8'd0, 1'b0, FK_NAME, 1'b0, 1'b1, 1'b0);
                end else begin
                    o_bundle.slot[0] = mk_res(8'd0, 1'b0, FK_VALUE, 1'b1, 1'b0, 1'b0);
                end
                cnt = 3'd1;
                n_state.hdr_part = HP_EMPTY;
                n_state.pend_sp  = 4'd0;
                n_state.match    = 4'd0;
            end
        end else if (r_state.cr_pend) begin
            use_a = 1'b1;
            if (i_byte == CH_CR) begin
                n_state         = l1.s;
                n_state.cr_pend = 1'b1;
            end else begin
                use_b   = 1'b1;
                n_state = l2.s;
                op      = l2.op;
            end
        end else if (i_byte == CH_CR) begin
            n_state.cr_pend = 1'b1;
        end else begin
            use_a   = 1'b1;
            n_state = l1.s;
            op      = l1.op;
        end

        // Gather the beats of the line byte units.
        if (use_a) begin
            o_bundle.spaces = sel_a.spaces;
            for (int k = 0; k < 2; k++) begin
                if (2'(k) < sel_a.n) begin
                    o_bundle.slot[cnt[1:0]] = sel_a.r[k];
                    cnt = cnt + 3'd1;
                end
            end
        end
        if (use_b) begin
            for (int k = 0; k < 2; k++) begin
                if ((2'(k) < sel_b.n) && (cnt < 3'd3)) begin
                    o_bundle.slot[cnt[1:0]] = sel_b.r[k];
                    cnt = cnt + 3'd1;
                end
            end
        end

        // Length accumulator.
        unique case (op)
            AO_CLEAR: n_acc = '0;
            AO_LOAD:  n_acc = LENGTH_BITS'(i_byte[3:0]);
            AO_MAC:   n_acc = prod[LENGTH_BITS-1:0];
            default:  n_acc = n_acc;
        endcase

        // An item with nothing else to report gives one status beat.
        if ((cnt == 3'd0) && (o_bundle.spaces == 4'd0)) begin
            o_bundle.slot[0] = '0;
            cnt = 3'd1;
        end
        o_bundle.nslots = cnt[1:0];
        o_bundle.perr   = (n_state.phase == PH_ERR);
    end

    // State registers, updated once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_acc   <= '0;
            r_rem   <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
        end
    end

    // Maximum body length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= 24'd1048576;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_data;
        end
    end

endmodule

/* src/hrsp_seq.sv */
module hrsp_seq
    import hrsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_bundle           i_bundle,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_out_ready,
    output t_res              o_res,
    output logic              o_perr,
    output logic [BLEN_W-1:0] o_blen,
    output logic              o_last
);

    t_bundle    r_cur;
    t_bundle    r_nxt;
    logic       r_cur_valid;
    logic       r_nxt_valid;
    logic [3:0] r_sp;
    logic [1:0] r_idx;

    logic is_sp;
    logic fire;
    logic cur_free;

    // Current beat: held spaces first, then the slots in order.
    assign is_sp = (r_sp < r_cur.spaces);
    always_comb begin
        if (is_sp) begin
            o_res  = mk_res(CH_SP, 1'b1, FK_NAME, 1'b0, 1'b0, 1'b0);
            o_last = ((r_sp + 4'd1) == r_cur.spaces) && (r_cur.nslots == 2'd0);
        end else begin
            o_res  = r_cur.slot[r_idx];
            o_last = (({1'b0, r_idx} + 3'd1) == {1'b0, r_cur.nslots});
        end
    end
    assign o_perr  = r_cur.perr;
    assign o_blen  = o_res.done ? r_cur.blen : '0;
    assign o_valid = r_cur_valid;
    assign o_ready = !r_nxt_valid;

    assign fire     = r_cur_valid && i_out_ready;
    assign cur_free = !r_cur_valid || (fire && o_last);

    // Two-deep bundle store: current and waiting.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_nxt_valid <= 1'b0;
            r_sp        <= 4'd0;
            r_idx       <= 2'd0;
        end else begin
            if (cur_free) begin
                r_sp  <= 4'd0;
                r_idx <= 2'd0;
                if (r_nxt_valid) begin
                    r_cur_valid <= 1'b1;
                    r_nxt_valid <= 1'b0;
                end else begin
                    r_cur_valid <= i_accept;
                end
            end else begin
                if (fire) begin
                    if (is_sp) begin
                        r_sp <= r_sp + 4'd1;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                if (i_accept) begin
                    r_nxt_valid <= 1'b1;
                end
            end
        end
    end

    // Bundle payload.
    always_ff @(posedge i_clk) begin
        if (cur_free) begin
            if (r_nxt_valid) begin
                r_cur <= r_nxt;
            end else if (i_accept) begin
                r_cur <= i_bundle;
            end
        end else if (i_accept) begin
            r_nxt <= i_bundle;
        end
    end

endmodule

/* src/http_request_stream_parser.sv */
// Channel   Dir  Beat contents
// i_in      in   in_byte, restart
// o_out     out  out_byte, out_valid, field_kind, field_end, drop_line,
//                request_done, parse_error, body_length, last
// i_cfg     in   i_cfg_we, i_cfg_data (max_body_length)
//
// Each input byte is parsed in the cycle it is accepted; its beats leave one per cycle
// while the receiver is ready. Most bytes give one beat, so one byte per cycle is
// sustained unless the output stalls. A byte that releases held header-name spaces
// gives up to SPACE_HOLD + 2 beats (at most ten, as no more than eight spaces are held).
// A two-entry bundle store lets a new byte in while a result beat is still stalled.
// Synchronous active-low reset returns the parser to the request line start.
module http_request_stream_parser
    import hrsp_pkg::*;
#(
    parameter int LENGTH_BITS = 24,
    parameter int SPACE_HOLD  = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hrsp_in_if.sink       i_in,
    hrsp_out_if.source    o_out,
    input  logic          i_cfg_we,
    input  logic [23:0]   i_cfg_data
);

    t_bundle           bundle;
    t_res              res;
    logic              accept;
    logic              seq_ready;
    logic              perr;
    logic              last;
    logic [BLEN_W-1:0] blen;

    assign accept     = i_in.valid && seq_ready;
    assign i_in.ready = seq_ready;

    // Byte parser with its state registers.
    hrsp_step #(
        .LENGTH_BITS (LENGTH_BITS),
        .SPACE_HOLD  (SPACE_HOLD)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_in.in_byte),
        .i_restart  (i_in.restart),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_bundle   (bundle)
    );

    // Output sequencer.
    hrsp_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_bundle    (bundle),
        .o_ready     (seq_ready),
        .o_valid     (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_res       (res),
        .o_perr      (perr),
        .o_blen      (blen),
        .o_last      (last)
    );

    // Result beat fields.
    assign o_out.out_byte     = res.data;
    assign o_out.out_valid    = res.valid;
    assign o_out.field_kind   = res.kind;
    assign o_out.field_end    = res.fend;
    assign o_out.drop_line    = res.drop;
    assign o_out.request_done = res.done;
    assign o_out.parse_error  = perr;
    assign o_out.body_length  = blen;
    assign o_out.last         = last;

endmodule

/* bench/tb_top.sv */
module tb_top;
    import hrsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One byte of the request stream, or a parser restart.
    typedef struct {
        logic [7:0] data;
        logic       restart;
    } t_feed;

    // One result beat as the parser should present it.
    typedef struct {
        logic [7:0]  data;
        logic        valid;
        t_kind       kind;
        logic        fend;
        logic        drop;
        logic        done;
        logic        perr;
        logic [23:0] blen;
        logic        last;
    } t_beat;

    localparam int HOLD_MAX = 8;
    localparam int MAX_BEATS = 10;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [23:0] i_cfg_data;

    hrsp_in_if  in_ch ();
    hrsp_out_if out_ch ();

    http_request_stream_parser i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    t_feed byte_feed[$];
    t_beat step_beats[$];
    t_beat expected_beats[$];
    int    mismatches = 0;
    int    fed_total = 0;
    logic  quiet = 1'b0;
    logic  long_hold = 1'b0;
    logic  hold_go = 1'b0;

    // Predictor state.
    t_phase      st_phase;
    logic [1:0]  st_tok;
    logic        st_in_tok;
    logic        st_query;
    logic [1:0]  st_pct;
    logic [7:0]  st_held;
    logic        st_cr;
    t_hpart      st_hpart;
    int          st_spaces;
    int          st_match;
    t_nstage     st_num;
    logic [23:0] st_accum;
    logic        st_len_seen;
    logic [23:0] st_remain;
    logic [23:0] st_max_len;
    string       length_key = "content-length";

    // Clock.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("beat mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- predictor

    task automatic put(input logic [7:0] d, input logic v, input t_kind k, input logic e,
                       input logic dr, input logic dn, input logic [23:0] bl);
        t_beat b;
        if (step_beats.size() < MAX_BEATS) begin
            b.data = d; b.valid = v; b.kind = k; b.fend = e; b.drop = dr; b.done = dn;
            b.perr = 1'b0; b.blen = bl; b.last = 1'b0;
            step_beats.insert(step_beats.size(), b);
        end
    endtask

    task automatic reset_parser();
        st_phase = PH_REQ; st_tok = 2'd0; st_in_tok = 1'b0; st_query = 1'b0;
        st_pct = 2'd0; st_held = 8'd0; st_cr = 1'b0; st_hpart = HP_EMPTY;
        st_spaces = 0; st_match = 0; st_num = NS_SKIP; st_accum = 24'd0;
        st_len_seen = 1'b0; st_remain = 24'd0;
    endtask

    function automatic logic blank(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
               c == CH_CR;
    endfunction

    // Hex digit value, or -1 for anything else.
    function automatic int nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    // Escape value as a base 16 conversion of two characters would give it.
    function automatic logic [7:0] escape_value(input logic [7:0] a, input logic [7:0] b);
        int ha;
        int hb;
        int v;
        ha = nibble(a);
        hb = nibble(b);
        if (ha >= 0) return hb >= 0 ? 8'(ha * 16 + hb) : 8'(ha);
        if (a == CH_PLUS || a == CH_MINUS) begin
            v = hb >= 0 ? hb : 0;
            return a == CH_MINUS ? 8'(256 - v) : 8'(v);
        end
        return 8'd0;
    endfunction

    task automatic path_plain(input logic [7:0] c);
        if (c == CH_PLUS) put(CH_SP, 1'b1, FK_PATH, 1'b0, 1'b0, 1'b0, 24'd0);
        else if (c != CH_PCT) put(c, 1'b1, FK_PATH, 1'b0, 1'b0, 1'b0, 24'd0);
    endtask

    task automatic path_flush();
        if (st_pct == 2'd2) path_plain(st_held);
        st_pct = 2'd0;
    endtask

    task automatic path_byte(input logic [7:0] c);
        if (st_query) return;
        if (c == CH_QM) begin
            path_flush();
            st_query = 1'b1;
        end else if (st_pct == 2'd1) begin
            st_held = c;
            st_pct = 2'd2;
        end else if (st_pct == 2'd2) begin
            put(escape_value(st_held, c), 1'b1, FK_PATH, 1'b0, 1'b0, 1'b0, 24'd0);
            st_pct = 2'd0;
        end else if (c == CH_PCT) begin
            st_pct = 2'd1;
        end else begin
            path_plain(c);
        end
    endtask

    task automatic close_token();
        if (st_tok == 2'd1) path_flush();
        if (st_tok < 2'd3) begin
            put(8'd0, 1'b0, t_kind'({1'b0, st_tok} + 3'd1), 1'b1, 1'b0, 1'b0, 24'd0);
            st_tok++;
        end
        st_in_tok = 1'b0; st_query = 1'b0; st_pct = 2'd0;
    endtask

    task automatic request_line_byte(input logic [7:0] c);
        if (blank(c)) begin
            if (st_in_tok) close_token();
            return;
        end
        st_in_tok = 1'b1;
        if (st_tok == 2'd1) path_byte(c);
        else if (st_tok < 2'd3)
            put(c, 1'b1, t_kind'({1'b0, st_tok} + 3'd1), 1'b0, 1'b0, 1'b0, 24'd0);
    endtask

    task automatic request_line_end();
        if (st_in_tok) close_token();
        if (st_tok < 2'd3) begin
            st_phase = PH_ERR;
            return;
        end
        st_phase = PH_HDR; st_tok = 2'd0; st_in_tok = 1'b0; st_query = 1'b0; st_pct = 2'd0;
        st_hpart = HP_EMPTY; st_spaces = 0; st_match = 0;
    endtask

    // Content length scanner: blanks, optional sign, decimal digits.
    task automatic length_byte(input logic [7:0] c);
        logic        dig;
        logic [63:0] n;
        dig = c >= CH_0 && c <= CH_9;
        case (st_num)
            NS_SKIP: begin
                if (!blank(c)) begin
                    if (c == CH_PLUS) st_num = NS_PLUS;
                    else if (c == CH_MINUS) st_num = NS_MINUS;
                    else if (dig) begin
                        st_accum = 24'(c - CH_0);
                        st_num = NS_DIGITS;
                    end else st_num = NS_BAD;
                end
            end
            NS_PLUS: begin
                if (dig) begin
                    st_accum = 24'(c - CH_0);
                    st_num = NS_DIGITS;
                end else st_num = NS_BAD;
            end
            NS_MINUS: st_num = dig ? NS_NEG : NS_BAD;
            NS_DIGITS: begin
                if (!dig) st_num = NS_STOP;
                else begin
                    n = 64'(st_accum) * 10 + 64'(c - CH_0);
                    if (n > 64'hFF_FFFF) st_num = NS_OVF;
                    else st_accum = 24'(n);
                end
            end
            default: ;
        endcase
    endtask

    task automatic header_byte(input logic [7:0] c);
        logic [7:0] lc;
        if (st_hpart == HP_SKIP || st_hpart == HP_VALUE) begin
            if (st_hpart == HP_SKIP && (c == CH_SP || c == CH_TAB)) return;
            st_hpart = HP_VALUE;
            put(c, 1'b1, FK_VALUE, 1'b0, 1'b0, 1'b0, 24'd0);
            if (st_match == 14) length_byte(c);
            return;
        end
        st_hpart = HP_NAME;
        if (c == CH_COLON) begin
            st_spaces = 0;
            put(8'd0, 1'b0, FK_NAME, 1'b1, 1'b0, 1'b0, 24'd0);
            st_hpart = HP_SKIP;
            if (st_match == 14) begin
                st_len_seen = 1'b1; st_accum = 24'd0; st_num = NS_SKIP;
            end
            return;
        end
        if (c == CH_SP) begin
            if (st_spaces < HOLD_MAX) st_spaces++;
            else put(CH_SP, 1'b1, FK_NAME, 1'b0, 1'b0, 1'b0, 24'd0);
            return;
        end
        // Held spaces were inside the name after all, so it cannot be the length name.
        if (st_spaces > 0) begin
            while (st_spaces > 0) begin
                put(CH_SP, 1'b1, FK_NAME, 1'b0, 1'b0, 1'b0, 24'd0);
                st_spaces--;
            end
            st_match = 15;
        end
        lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
        if (st_match < 14 && lc == length_key[st_match]) st_match++;
        else st_match = 15;
        put(lc, 1'b1, FK_NAME, 1'b0, 1'b0, 1'b0, 24'd0);
    endtask

    task automatic header_line_end();
        if (st_hpart == HP_EMPTY) begin
            if (st_len_seen && (st_num == NS_DIGITS || st_num == NS_STOP) && st_accum > 0)
            begin
                if (st_accum > st_max_len) st_phase = PH_ERR;
                else begin
                    st_phase = PH_BODY;
                    st_remain = st_accum;
                end
            end else if (st_len_seen && st_num == NS_OVF) begin
                st_phase = PH_ERR;
            end else begin
                put(8'd0, 1'b0, FK_NONE, 1'b0, 1'b0, 1'b1, 24'd0);
                reset_parser();
            end
            return;
        end
        if (st_hpart == HP_NAME) put(8'd0, 1'b0, FK_NAME, 1'b0, 1'b1, 1'b0, 24'd0);
        else put(8'd0, 1'b0, FK_VALUE, 1'b1, 1'b0, 1'b0, 24'd0);
        st_hpart = HP_EMPTY; st_spaces = 0; st_match = 0;
    endtask

    task automatic line_byte(input logic [7:0] c);
        if (st_phase == PH_REQ) request_line_byte(c);
        else header_byte(c);
    endtask

    task automatic parse_byte(input logic [7:0] c);
        if (st_phase == PH_ERR) return;
        if (st_phase == PH_BODY) begin
            st_remain = st_remain - 24'd1;
            if (st_remain == 24'd0) begin
                put(c, 1'b1, FK_BODY, 1'b1, 1'b0, 1'b1, st_accum);
                reset_parser();
            end else begin
                put(c, 1'b1, FK_BODY, 1'b0, 1'b0, 1'b0, 24'd0);
            end
            return;
        end
        if (st_cr) begin
            st_cr = 1'b0;
            if (c == CH_LF) begin
                if (st_phase == PH_REQ) request_line_end();
                else header_line_end();
                return;
            end
            line_byte(CH_CR);
        end
        if (c == CH_CR) st_cr = 1'b1;
        else line_byte(c);
    endtask

    // Works out every beat that one accepted item causes.
    task automatic predict_beats(input t_feed it);
        step_beats.delete();
        if (it.restart) reset_parser();
        else parse_byte(it.data);
        if (step_beats.size() == 0) put(8'd0, 1'b0, FK_NONE, 1'b0, 1'b0, 1'b0, 24'd0);
        foreach (step_beats[k]) begin
            step_beats[k].perr = st_phase == PH_ERR;
            step_beats[k].last = k == step_beats.size() - 1;
            expected_beats.insert(expected_beats.size(), step_beats[k]);
        end
    endtask

    // ---------------------------------------------------------------- driver

    t_feed cur_item;
    logic  have_item = 1'b0;
    int    in_gap = 0;

    always @(posedge i_clk) begin
        t_feed nxt;
        logic  have;
        nxt = cur_item;
        have = have_item;
        if (!i_rst_n) begin
            have = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_beats(cur_item);
                have = 1'b0;
            end
            if (in_gap > 0) begin
                in_gap--;
            end else if (!have && !quiet && $urandom_range(0, 15) == 0) begin
                in_gap = $urandom_range(1, 17);
            end else if (!have && byte_feed.size() > 0) begin
                nxt = byte_feed.pop_front();
                have = 1'b1;
            end
        end
        cur_item <= nxt;
        have_item <= have;
        in_ch.valid <= have;
        in_ch.in_byte <= nxt.data;
        in_ch.restart <= nxt.restart;
    end

    // ---------------------------------------------------------------- monitor

    int out_stall = 0;

    always @(posedge i_clk) begin
        t_beat w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_beats.size() == 0) begin
                report("unexpected beat", out_ch.out_byte, 0);
            end else begin
                w = expected_beats.pop_front();
                if (out_ch.out_byte !== w.data) report("out_byte", out_ch.out_byte, w.data);
                if (out_ch.out_valid !== w.valid)
                    report("out_valid", out_ch.out_valid, w.valid);
                if (out_ch.field_kind !== w.kind)
                    report("field_kind", out_ch.field_kind, w.kind);
                if (out_ch.field_end !== w.fend) report("field_end", out_ch.field_end, w.fend);
                if (out_ch.drop_line !== w.drop) report("drop_line", out_ch.drop_line, w.drop);
                if (out_ch.request_done !== w.done)
                    report("request_done", out_ch.request_done, w.done);
                if (out_ch.parse_error !== w.perr)
                    report("parse_error", out_ch.parse_error, w.perr);
                if (out_ch.body_length !== w.blen)
                    report("body_length", out_ch.body_length, w.blen);
                if (out_ch.last !== w.last) report("last", out_ch.last, w.last);
            end
        end
        if (out_stall > 0) out_stall--;
        else if (!quiet && $urandom_range(0, 15) == 0) out_stall = $urandom_range(1, 17);
        out_ch.ready <= i_rst_n && out_stall == 0 && !long_hold;
    end

    // Long receiver hold-off so the parser fills up and stalls its input.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // ---------------------------------------------------------------- stimulus

    task automatic add_byte(input logic [7:0] b);
        t_feed f;
        f.data = b;
        f.restart = 1'b0;
        byte_feed.insert(byte_feed.size(), f);
        fed_total++;
    endtask

    task automatic add_restart();
        t_feed f;
        f.data = 8'($urandom);
        f.restart = 1'b1;
        byte_feed.insert(byte_feed.size(), f);
        fed_total++;
    endtask

    task automatic add_text(input string s);
        foreach (s[i]) add_byte(s[i]);
    endtask

    function automatic logic [7:0] pick(input string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    // A mostly well-formed request with random content.
    task automatic add_request();
        int    n;
        int    blen;
        string num;
        add_restart();
        n = $urandom_range(1, 5);
        repeat (n) add_byte(pick("GETPOSHADUXg"));
        add_byte(pick(" \t"));
        n = $urandom_range(0, 10);
        add_byte("/");
        repeat (n) add_byte(pick("ab/%+?4Fz-x%"));
        // Now and then the line is cut short.
        if ($urandom_range(0, 9) != 0) begin
            add_byte(" ");
            add_text("HTTP/1.1");
        end
        add_text("\r\n");
        blen = 0;
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 6))
                0: add_text("Content-Length");
                1: add_text("content-LENGTH");
                2: add_text("Content-Length  ");
                3: add_text("Content Length");
                4: add_text("Host");
                5: add_text("X        Y");
                default: repeat ($urandom_range(1, 4)) add_byte(pick("aZ- \r\n"));
            endcase
            if ($urandom_range(0, 7) != 0) add_byte(":");
            repeat ($urandom_range(0, 2)) add_byte(pick(" \t"));
            blen = $urandom_range(0, 5);
            case ($urandom_range(0, 9))
                0: num = "-2";
                1: num = "x1";
                2: num = $sformatf("+%0d", blen);
                3: num = "20000000";
                default: num = $sformatf("%0d", blen);
            endcase
            add_text(num);
            add_text("\r\n");
        end
        add_text("\r\n");
        repeat (blen) add_byte(8'($urandom));
    endtask

    task automatic add_noise();
        add_restart();
        repeat ($urandom_range(2, 12)) add_byte(8'($urandom));
    endtask

    // Waits until every beat has come and the parser has settled.
    task automatic drain();
        while (byte_feed.size() > 0 || have_item || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [23:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        st_max_len = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [23:0] settings[4];
        int          made;
        settings = '{24'd0, 24'hFF_FFFF, 24'd3, 24'd1048576};
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'd0;
        in_ch.restart = 1'b0;
        out_ch.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 24'd0;
        reset_parser();
        st_max_len = 24'd1048576;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: escapes, short path escape, lone CR, dropped line, short request line,
        // length overflow and a body under the reset limit.
        add_text("G /%4+%-5%zz?q\rV\r\nA          b\r\n\r\n");
        add_text("C\r\nq");
        add_restart();
        add_text("M / V\r\nContent-Length:99999999\r\n\r\n");
        add_restart();
        add_text("M / V\r\ncontent-length: 2\r\n\r\n");
        add_byte(8'hFF);
        add_byte(8'h00);
        drain();

        // Random requests under each length limit, the receiver held off once.
        foreach (settings[s]) begin
            write_max_length(settings[s]);
            repeat (20) @(posedge i_clk);
            if (s == 0) hold_go = 1'b1;
            made = fed_total;
            while (fed_total - made < 25) begin
                if ($urandom_range(0, 5) == 0) add_noise();
                else add_request();
                if (s == 3 && fed_total - made > 12) quiet = 1'b1;
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Timeout.
    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
